@@ rtl/acsc_pkg.sv @@
// shared types, chunk type codes and classification for the apng chunk sequence checker
package acsc_pkg;

   typedef struct packed {
      logic [31:0] chunk_type;
      logic [30:0] chunk_length;
      logic [31:0] first_word;
      logic [31:0] second_word;
      logic        is_last;
   } chunk_req_type;

   typedef struct packed {
      logic        png_ok;
      logic        apng_ok;
      logic [15:0] first_data_index;
      logic        cover_frame;
      logic [31:0] frame_total;
      logic [31:0] loop_total;
   } chunk_rsp_type;

   typedef enum logic [2:0] {
      CL_NONE  = 3'd0,
      CL_IHDR  = 3'd1,
      CL_IDAT  = 3'd2,
      CL_ACTL  = 3'd3,
      CL_FCTL  = 3'd4,
      CL_FDAT  = 3'd5,
      CL_IEND  = 3'd6,
      CL_OTHER = 3'd7
   } chunk_class_type;

   // four type characters, first character in the low byte
   localparam logic [31:0] TypeIhdr = 32'h5244_4849;
   localparam logic [31:0] TypeIdat = 32'h5441_4449;
   localparam logic [31:0] TypeActl = 32'h4C54_6361;
   localparam logic [31:0] TypeFctl = 32'h4C54_6366;
   localparam logic [31:0] TypeFdat = 32'h5441_6466;
   localparam logic [31:0] TypeIend = 32'h444E_4549;

   localparam logic [30:0] LenHeader   = 31'd13;
   localparam logic [30:0] LenAnimCtl  = 31'd8;
   localparam logic [30:0] LenFrameCtl = 31'd26;
   localparam logic [30:0] LenSeqField = 31'd4;

   // per-list tracking state, chunk counter kept apart since its width is a parameter
   typedef struct packed {
      chunk_class_type prev_class;
      logic            header_seen;
      logic            header_good;
      logic            data_seen;
      logic            control_seen;
      logic            frame_control_seen;
      logic            pending_frame_control;
      logic [15:0]     first_data_pos;
      logic            cover_flag;
      logic [31:0]     expected_sequence;
      logic            declared_valid;
      logic [31:0]     declared_frames;
      logic [31:0]     seen_frames;
      logic [31:0]     loop_value;
      logic            field_error;
      logic            order_error;
   } tracker_state_type;

   localparam tracker_state_type TrackerReset = '{
      prev_class:            CL_NONE,
      header_seen:           1'b0,
      header_good:           1'b0,
      data_seen:             1'b0,
      control_seen:          1'b0,
      frame_control_seen:    1'b0,
      pending_frame_control: 1'b0,
      first_data_pos:        16'd0,
      cover_flag:            1'b0,
      expected_sequence:     32'd0,
      declared_valid:        1'b0,
      declared_frames:       32'd0,
      seen_frames:           32'd0,
      loop_value:            32'd0,
      field_error:           1'b0,
      order_error:           1'b0
   };

   function automatic chunk_class_type classify(input logic [31:0] code);
      chunk_class_type cls;
      priority if (code == TypeIhdr) cls = CL_IHDR;
      else if (code == TypeIdat) cls = CL_IDAT;
      else if (code == TypeActl) cls = CL_ACTL;
      else if (code == TypeFctl) cls = CL_FCTL;
      else if (code == TypeFdat) cls = CL_FDAT;
      else if (code == TypeIend) cls = CL_IEND;
      else cls = CL_OTHER;
      return cls;
   endfunction

endpackage

@@ rtl/acsc_tracker.sv @@
// per-list chunk order and field tracker with the end-of-list verdict logic
module acsc_tracker import acsc_pkg::*; #(
   parameter int MAX_CHUNKS = 65536
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step_valid,
   input  chunk_req_type step_data,
   output chunk_rsp_type result
);

   localparam int IW = $clog2(MAX_CHUNKS + 2);
   localparam logic [IW-1:0] MaxIdx = IW'(MAX_CHUNKS);
   localparam logic [IW-1:0] SatIdx = IW'(MAX_CHUNKS + 1);
   localparam logic [IW-1:0] MinChunks = IW'(3);

   logic [IW-1:0]     chunk_index_ff, chunk_index_in;
   tracker_state_type state_ff, state_in;
   chunk_class_type   cls;
   logic [IW-1:0]     idx;
   tracker_state_type upd;
   logic              png, apng;

   assign cls = classify(step_data.chunk_type);
   assign idx = (chunk_index_ff == SatIdx) ? MaxIdx : chunk_index_ff;

   always_comb begin
      upd = state_ff;
      chunk_index_in = chunk_index_ff;

      // field checks
      if (cls == CL_ACTL) begin
         if (step_data.chunk_length == LenAnimCtl) begin
            upd.declared_valid  = 1'b1;
            upd.declared_frames = step_data.first_word;
            upd.loop_value      = step_data.second_word;
         end else begin
            upd.field_error = 1'b1;
         end
      end
      if (cls == CL_FCTL) begin
         if (step_data.chunk_length != LenFrameCtl) upd.field_error = 1'b1;
         else upd.seen_frames = state_ff.seen_frames + 32'd1;
      end
      if (cls == CL_FCTL || cls == CL_FDAT) begin
         if (step_data.chunk_length > LenSeqField &&
             step_data.first_word == state_ff.expected_sequence) begin
            upd.expected_sequence = state_ff.expected_sequence + 32'd1;
         end else begin
            upd.field_error = 1'b1;
         end
      end

      // the chunk after a fcTL settles that fcTL
      if (state_ff.pending_frame_control) begin
         if (cls != CL_FDAT && cls != CL_IDAT) upd.order_error = 1'b1;
         if (!state_ff.frame_control_seen && cls == CL_IDAT) upd.cover_flag = 1'b1;
         upd.frame_control_seen    = 1'b1;
         upd.pending_frame_control = 1'b0;
      end

      // order checks
      if (idx == '0) begin
         if (cls == CL_IHDR) begin
            upd.header_seen = 1'b1;
            upd.header_good = (step_data.chunk_length == LenHeader);
         end else begin
            upd.order_error = 1'b1;
         end
      end else if (cls == CL_IHDR) begin
         upd.order_error = 1'b1;
      end

      unique case (cls)
         CL_IDAT: begin
            if (state_ff.prev_class != CL_IDAT) begin
               if (!state_ff.data_seen) begin
                  upd.data_seen      = 1'b1;
                  upd.first_data_pos = 16'(idx);
               end else begin
                  upd.order_error = 1'b1;
               end
            end
         end
         CL_ACTL: begin
            if (state_ff.control_seen) upd.order_error = 1'b1;
            upd.control_seen = 1'b1;
         end
         CL_FCTL: begin
            if (step_data.is_last) upd.order_error = 1'b1;
            upd.pending_frame_control = 1'b1;
         end
         CL_FDAT: begin
            if (state_ff.prev_class != CL_FDAT && state_ff.prev_class != CL_FCTL) begin
               upd.order_error = 1'b1;
            end
         end
         default: begin
         end
      endcase

      upd.prev_class = cls;
      if (chunk_index_ff != SatIdx) chunk_index_in = chunk_index_ff + IW'(1);

      png  = (chunk_index_in != SatIdx) && (chunk_index_in >= MinChunks) && upd.header_good;
      apng = png && !upd.field_error && !upd.order_error && upd.declared_valid &&
             (upd.declared_frames != 32'd0) && (upd.declared_frames == upd.seen_frames) &&
             upd.header_seen && upd.data_seen && upd.control_seen &&
             (upd.seen_frames != 32'd0) && (cls == CL_IEND);

      result.png_ok           = png;
      result.apng_ok          = apng;
      result.first_data_index = apng ? upd.first_data_pos : 16'd0;
      result.cover_frame      = apng && upd.cover_flag;
      result.frame_total      = apng ? upd.declared_frames : 32'd0;
      result.loop_total       = apng ? upd.loop_value : 32'd0;

      // last chunk closes the list, the next transaction starts fresh
      state_in = upd;
      if (step_data.is_last) begin
         state_in       = TrackerReset;
         chunk_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= TrackerReset;
         chunk_index_ff <= '0;
      end else if (step_valid) begin
         state_ff       <= state_in;
         chunk_index_ff <= chunk_index_in;
      end
   end

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      chunk_index_ff <= SatIdx)
      else $error("chunk counter past saturation");

   a_list_restart: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_data.is_last |=>
         chunk_index_ff == '0 && !state_ff.pending_frame_control && !state_ff.order_error)
      else $error("state not cleared after last chunk");

   a_pending_after_fctl: assert property (@(posedge clock) disable iff (reset)
      step_valid && cls == CL_FCTL && !step_data.is_last |=> state_ff.pending_frame_control)
      else $error("fcTL follow-up not armed");

endmodule

@@ rtl/apng_chunk_sequence_checker.sv @@
// top level: input register, chunk tracker and result register with handshakes
// result path: the result is registered in the result register when its last chunk leaves the input register
// throughput: one chunk transaction per cycle while the input is not stalled
// only a last chunk waits on the result register; other chunks pass even while it stalls
// reset: synchronous, clears both valid flags and all tracking state to an empty list
module apng_chunk_sequence_checker import acsc_pkg::*; #(
   parameter int MAX_CHUNKS = 65536
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  chunk_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output chunk_rsp_type rsp_data
);

   logic          s1_valid_ff, s1_valid_in;
   chunk_req_type s1_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   chunk_rsp_type rsp_data_ff;
   chunk_rsp_type result;
   logic          advance;
   logic          req_take;

   assign advance   = s1_valid_ff && (!s1_data_ff.is_last || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   acsc_tracker #(
      .MAX_CHUNKS(MAX_CHUNKS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_data  (s1_data_ff),
      .result     (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) s1_valid_in = 1'b1;
      else if (advance) s1_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance && s1_data_ff.is_last) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_data_ff <= req_data;
      if (advance && s1_data_ff.is_last) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && s1_data_ff.is_last))
      else $error("result raised without a last chunk");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_data_ff.is_last && rsp_valid_ff)
      else $error("input stalled with no blocked last chunk");

   a_apng_implies_png: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.apng_ok || rsp_data_ff.png_ok))
      else $error("animation verdict without basic png verdict");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the apng chunk sequence checker: directed lists, back pressure, random lists
module tb_top import acsc_pkg::*;;

   localparam int MaxChunks   = 65536;
   localparam int ResetCycles = 9;
   localparam int HoldCycles  = 200;
   localparam int StaleLimit  = 4000;
   localparam int DrainCycles = 8;

   typedef enum int {
      FLAW_RETYPE,
      FLAW_LENGTH,
      FLAW_WORD,
      FLAW_DROP,
      FLAW_REPEAT,
      FLAW_SWAP
   } flaw_type;

   // running view of the chunk list seen so far
   typedef struct packed {
      logic [16:0]     count;
      chunk_class_type prev;
      logic            hdr_seen;
      logic            hdr_good;
      logic            idat_seen;
      logic            actl_seen;
      logic            fctl_done;
      logic            fctl_open;
      logic [15:0]     idat_pos;
      logic            cover_seen;
      logic [31:0]     next_seq;
      logic            frames_known;
      logic [31:0]     frames_declared;
      logic [31:0]     frames_counted;
      logic [31:0]     loops;
      logic            field_bad;
      logic            order_bad;
   } list_track_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   chunk_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   chunk_rsp_type rsp_data;

   list_track_type trk;
   chunk_rsp_type  expected_rsps[$];
   chunk_rsp_type  want_rsp;
   chunk_req_type  chunk_list[$];
   int             errors;
   int             stale_cycles;
   int             chunks_sent;
   bit             quiet;
   bit             sender_gaps;
   bit             hold_request;

   apng_chunk_sequence_checker #(.MAX_CHUNKS(MaxChunks)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic chunk_class_type class_of(input logic [31:0] code);
      case (code)
         TypeIhdr: return CL_IHDR;
         TypeIdat: return CL_IDAT;
         TypeActl: return CL_ACTL;
         TypeFctl: return CL_FCTL;
         TypeFdat: return CL_FDAT;
         TypeIend: return CL_IEND;
         default:  return CL_OTHER;
      endcase
   endfunction

   task automatic clear_tracker();
      trk = '0;
      trk.prev = CL_NONE;
   endtask

   // update the list view with one chunk and queue the verdict on the last one
   task automatic track_chunk(input chunk_req_type c);
      chunk_class_type cls;
      logic [16:0]     pos;
      logic            overflow;
      logic            png;
      logic            apng;
      chunk_rsp_type   r;
      cls = class_of(c.chunk_type);
      pos = (trk.count > MaxChunks) ? 17'(MaxChunks) : trk.count;
      if (cls == CL_ACTL) begin
         if (c.chunk_length == LenAnimCtl) begin
            trk.frames_known    = 1'b1;
            trk.frames_declared = c.first_word;
            trk.loops           = c.second_word;
         end else begin
            trk.field_bad = 1'b1;
         end
      end
      if (cls == CL_FCTL) begin
         if (c.chunk_length != LenFrameCtl) trk.field_bad = 1'b1;
         else trk.frames_counted++;
      end
      if (cls == CL_FCTL || cls == CL_FDAT) begin
         if (c.chunk_length > LenSeqField && c.first_word == trk.next_seq) trk.next_seq++;
         else trk.field_bad = 1'b1;
      end
      // a fcTL is judged by the chunk right after it
      if (trk.fctl_open) begin
         if (cls != CL_FDAT && cls != CL_IDAT) trk.order_bad = 1'b1;
         if (!trk.fctl_done && cls == CL_IDAT) trk.cover_seen = 1'b1;
         trk.fctl_done = 1'b1;
         trk.fctl_open = 1'b0;
      end
      if (pos == 0) begin
         if (cls == CL_IHDR) begin
            trk.hdr_seen = 1'b1;
            trk.hdr_good = (c.chunk_length == LenHeader);
         end else begin
            trk.order_bad = 1'b1;
         end
      end else if (cls == CL_IHDR) begin
         trk.order_bad = 1'b1;
      end
      case (cls)
         CL_IDAT: begin
            if (trk.prev != CL_IDAT) begin
               if (!trk.idat_seen) begin
                  trk.idat_seen = 1'b1;
                  trk.idat_pos  = pos[15:0];
               end else begin
                  trk.order_bad = 1'b1;
               end
            end
         end
         CL_ACTL: begin
            if (trk.actl_seen) trk.order_bad = 1'b1;
            trk.actl_seen = 1'b1;
         end
         CL_FCTL: begin
            if (c.is_last) trk.order_bad = 1'b1;
            trk.fctl_open = 1'b1;
         end
         CL_FDAT: begin
            if (trk.prev != CL_FDAT && trk.prev != CL_FCTL) trk.order_bad = 1'b1;
         end
         default: ;
      endcase
      trk.prev = cls;
      if (trk.count <= MaxChunks) trk.count++;
      if (c.is_last) begin
         overflow = (trk.count > MaxChunks);
         png  = !overflow && trk.count >= 3 && trk.hdr_good;
         apng = png && !trk.field_bad && !trk.order_bad && trk.frames_known &&
                trk.frames_declared != 0 && trk.frames_declared == trk.frames_counted &&
                trk.hdr_seen && trk.idat_seen && trk.actl_seen && cls == CL_IEND;
         r = '0;
         r.png_ok  = png;
         r.apng_ok = apng;
         if (apng) begin
            r.first_data_index = trk.idat_pos;
            r.cover_frame      = trk.cover_seen;
            r.frame_total      = trk.frames_declared;
            r.loop_total       = trk.loops;
         end
         expected_rsps.push_back(r);
         clear_tracker();
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stale_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stale_cycles = 0;
         else stale_cycles++;
         if (req_valid && !req_stall) track_chunk(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t ns: result with none expected, expected nothing actual %h",
                        $time, rsp_data);
               errors++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               compare_field("png_ok", want_rsp.png_ok, rsp_data.png_ok);
               compare_field("apng_ok", want_rsp.apng_ok, rsp_data.apng_ok);
               compare_field("first_data_index", want_rsp.first_data_index,
                             rsp_data.first_data_index);
               compare_field("cover_frame", want_rsp.cover_frame, rsp_data.cover_frame);
               compare_field("frame_total", want_rsp.frame_total, rsp_data.frame_total);
               compare_field("loop_total", want_rsp.loop_total, rsp_data.loop_total);
            end
         end
      end
   end

   // result side: random stall bursts, calm stretches, and one long hold-off on request
   always begin
      @(negedge clock);
      if (hold_request) begin
         hold_request = 1'b0;
         rsp_stall <= 1'b1;
         repeat (HoldCycles) @(negedge clock);
         rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 20)) @(negedge clock);
      end
   end

   initial begin
      do @(posedge clock); while (stale_cycles < StaleLimit);
      $display("** apng_chunk_sequence_checker: FAILED **");
      $finish;
   end

   function automatic chunk_req_type make_chunk(input logic [31:0] code,
                                                input logic [30:0] len,
                                                input logic [31:0] w0,
                                                input logic [31:0] w1,
                                                input logic last);
      chunk_req_type c;
      c.chunk_type   = code;
      c.chunk_length = len;
      c.first_word   = w0;
      c.second_word  = w1;
      c.is_last      = last;
      return c;
   endfunction

   function automatic logic [30:0] rand_length(input logic [30:0] least);
      logic [30:0] len;
      case ($urandom_range(0, 3))
         0:       len = least;
         1:       len = 31'($urandom);
         default: len = least + 31'($urandom_range(0, 3000));
      endcase
      return (len < least) ? least : len;
   endfunction

   function automatic logic [30:0] odd_length();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return LenSeqField;
         2:       return LenSeqField + 31'd1;
         3:       return LenAnimCtl;
         4:       return LenHeader;
         5:       return LenFrameCtl;
         6:       return 31'h7FFF_FFFF;
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_type();
      case ($urandom_range(0, 6))
         0:       return TypeIhdr;
         1:       return TypeIdat;
         2:       return TypeActl;
         3:       return TypeFctl;
         4:       return TypeFdat;
         5:       return TypeIend;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_loops();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   // one transaction on the chunk side, with an optional idle burst ahead of it
   task automatic send_chunk(input chunk_req_type c);
      if (sender_gaps && !quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_data  <= c;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      chunks_sent++;
   endtask

   task automatic add_chunk(input logic [31:0] code, input logic [30:0] len,
                            input logic [31:0] w0, input logic [31:0] w1);
      chunk_list.push_back(make_chunk(code, len, w0, w1, 1'b0));
   endtask

   task automatic send_list();
      chunk_req_type c;
      foreach (chunk_list[i]) begin
         c = chunk_list[i];
         c.is_last = (i == chunk_list.size() - 1);
         send_chunk(c);
      end
      chunk_list.delete();
   endtask

   task automatic add_extras(input int most);
      repeat ($urandom_range(0, most)) add_chunk($urandom, rand_length(0), $urandom, $urandom);
   endtask

   task automatic add_data_run();
      repeat ($urandom_range(1, 3)) add_chunk(TypeIdat, rand_length(0), $urandom, $urandom);
   endtask

   task automatic build_animation(input int frames, input bit cover_first);
      logic [31:0] seq;
      int          f;
      seq = '0;
      chunk_list.delete();
      add_chunk(TypeIhdr, LenHeader, $urandom, $urandom);
      add_extras(2);
      add_chunk(TypeActl, LenAnimCtl, frames, pick_loops());
      if (!cover_first) add_data_run();
      for (f = 0; f < frames; f++) begin
         add_chunk(TypeFctl, LenFrameCtl, seq, $urandom);
         seq++;
         if (f == 0 && cover_first) begin
            add_data_run();
         end else begin
            repeat ($urandom_range(1, 3)) begin
               add_chunk(TypeFdat, rand_length(LenSeqField + 31'd1), seq, $urandom);
               seq++;
            end
         end
         add_extras(1);
      end
      add_chunk(TypeIend, '0, $urandom, $urandom);
   endtask

   task automatic build_still();
      chunk_list.delete();
      add_chunk(TypeIhdr, LenHeader, $urandom, $urandom);
      add_extras(2);
      add_data_run();
      add_extras(2);
      add_chunk(TypeIend, '0, $urandom, $urandom);
   endtask

   task automatic build_noise();
      chunk_list.delete();
      repeat ($urandom_range(1, 8))
         add_chunk(pick_type(), odd_length(),
                   $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom, $urandom);
   endtask

   // put one flaw into the list built so far, at a random chunk
   task automatic damage_list();
      flaw_type      flaw;
      int            n;
      int            i;
      chunk_req_type c;
      n = chunk_list.size();
      i = $urandom_range(0, n - 1);
      c = chunk_list[i];
      flaw = flaw_type'($urandom_range(FLAW_RETYPE, FLAW_SWAP));
      case (flaw)
         FLAW_RETYPE: begin
            c.chunk_type = pick_type();
            chunk_list[i] = c;
         end
         FLAW_LENGTH: begin
            c.chunk_length = odd_length();
            chunk_list[i] = c;
         end
         FLAW_WORD: begin
            c.first_word = c.first_word + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            chunk_list[i] = c;
         end
         FLAW_DROP: begin
            if (n > 1) chunk_list.delete(i);
         end
         FLAW_REPEAT: begin
            chunk_list.insert(i, c);
         end
         FLAW_SWAP: begin
            if (i + 1 < n) begin
               chunk_list[i]     = chunk_list[i + 1];
               chunk_list[i + 1] = c;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_random_list();
      int pick;
      int frames;
      pick   = $urandom_range(0, 99);
      frames = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (pick < 55) begin
         build_animation(frames, $urandom_range(0, 1));
      end else if (pick < 65) begin
         build_still();
      end else if (pick < 85) begin
         build_animation(frames, $urandom_range(0, 1));
         repeat ($urandom_range(1, 2)) damage_list();
      end else begin
         build_noise();
      end
      send_list();
   endtask

   task automatic test_directed();
      sender_gaps = 1'b1;
      // smallest animation, default image is the first frame
      add_chunk(TypeIhdr, LenHeader, '0, '0);
      add_chunk(TypeActl, LenAnimCtl, 1, '0);
      add_chunk(TypeFctl, LenFrameCtl, '0, '0);
      add_chunk(TypeIdat, '0, '0, '0);
      add_chunk(TypeIend, '0, '0, '0);
      send_list();
      // early IEND counts as an ordinary chunk, extreme lengths and words
      add_chunk(TypeIhdr, LenHeader, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_chunk(TypeActl, LenAnimCtl, 1, 32'hFFFF_FFFF);
      add_chunk(TypeIdat, 31'h7FFF_FFFF, 32'hFFFF_FFFF, '0);
      add_chunk(TypeIend, '0, '0, '0);
      add_chunk(TypeFctl, LenFrameCtl, '0, 32'hFFFF_FFFF);
      add_chunk(TypeFdat, 31'h7FFF_FFFF, 1, '0);
      add_chunk(TypeIend, '0, '0, '0);
      send_list();
      // unknown chunk type in first place
      add_chunk(32'hFFFF_FFFF, LenHeader, '0, '0);
      add_chunk(TypeIdat, '0, '0, '0);
      add_chunk(TypeIend, '0, '0, '0);
      send_list();
      // bad acTL length, later good acTL, short fcTL and fdAT
      add_chunk(TypeIhdr, LenHeader, '0, '0);
      add_chunk(TypeActl, LenAnimCtl + 31'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_chunk(TypeActl, LenAnimCtl, 2, 5);
      add_chunk(TypeFctl, LenSeqField, '0, '0);
      add_chunk(TypeFdat, LenSeqField, '0, '0);
      add_chunk(TypeIend, '0, '0, '0);
      send_list();
      // lone header
      add_chunk(TypeIhdr, LenHeader, '0, '0);
      send_list();
      // fcTL closing the list
      add_chunk(TypeIhdr, LenHeader, '0, '0);
      add_chunk(TypeActl, LenAnimCtl, 1, '0);
      add_chunk(TypeFctl, LenFrameCtl, '0, '0);
      send_list();
   endtask

   // result side held off long enough that last chunks back up into the input
   task automatic test_backpressure();
      int k;
      sender_gaps  = 1'b0;
      hold_request = 1'b1;
      for (k = 0; k < 10; k++) begin
         build_animation(1, k[0]);
         send_list();
      end
   endtask

   task automatic test_random_lists();
      int start;
      start = chunks_sent;
      while (chunks_sent - start < 1200) send_random_list();
   endtask

   task automatic test_steady_tail();
      int start;
      quiet = 1'b1;
      start = chunks_sent;
      while (chunks_sent - start < 150) send_random_list();
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      quiet        = 1'b0;
      sender_gaps  = 1'b1;
      hold_request = 1'b0;
      errors       = 0;
      chunks_sent  = 0;
      stale_cycles = 0;
      clear_tracker();
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_lists();
      test_steady_tail();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("** apng_chunk_sequence_checker: PASSED **");
      end else begin
         $display("** apng_chunk_sequence_checker: FAILED **");
      end
      $finish;
   end

endmodule
